@@ src/rvlc_pkg.sv @@
// rvlc_pkg: shared types and fixed widths for the rvl depth compressor
// no dependencies; imported by rvlc_packer, rvl_depth_compressor and the bench files
`default_nettype none

package rvlc_pkg;

   localparam int PIXEL_W          = 16;  // width of the pixel port
   localparam int ZRUN_W           = 32;  // zero run counter and vle shifter width
   localparam int VLE_DIGIT_W      = 3;   // data bits per vle nibble
   localparam int NIBBLE_W         = 4;   // data bits plus continuation bit
   localparam int WORD_W           = 32;  // packed output word
   localparam int NIBBLES_PER_WORD = 8;
   localparam int NIB_CNT_W        = 3;   // counts nibbles within one word

   localparam logic [ZRUN_W-1:0] ZRUN_MAX = '1;

   // one vle nibble on its way to the word packer
   typedef struct packed {
      logic [NIBBLE_W-1:0] code;
      logic                frame_end;  // last nibble of the frame
   } nibble_type;

endpackage

`default_nettype wire

@@ src/rvlc_packer.sv @@
// rvlc_packer: packs vle nibbles eight to a word, first nibble on top
// depends on rvlc_pkg; holds the result channel output register
`default_nettype none

module rvlc_packer
   import rvlc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              nib_valid,
   input  wire nibble_type        nib,
   output logic                   nib_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [WORD_W-1:0]      rsp_code_word,
   output logic                   rsp_frame_end
);

   logic [NIB_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]    part_ff, part_in;
   logic                 valid_ff, valid_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic                 fend_ff, fend_in;
   logic [NIB_CNT_W-1:0] lane;
   logic [WORD_W-1:0]    filled;
   logic                 nib_fire;

   assign nib_ready = !valid_ff || rsp_ready;
   assign nib_fire  = nib_valid && nib_ready;
   assign lane      = ~cnt_ff;

   // drop the nibble into its lane, lower lanes stay zero as padding
   always_comb begin
      filled = part_ff;
      filled[{lane, 2'b00} +: NIBBLE_W] = nib.code;
   end

   always_comb begin
      cnt_in   = cnt_ff;
      part_in  = part_ff;
      valid_in = valid_ff;
      word_in  = word_ff;
      fend_in  = fend_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (nib_fire) begin
         if (cnt_ff == NIB_CNT_W'(NIBBLES_PER_WORD - 1) || nib.frame_end) begin
            valid_in = 1'b1;
            word_in  = filled;
            fend_in  = nib.frame_end;
            part_in  = '0;
            cnt_in   = '0;
         end else begin
            part_in = filled;
            cnt_in  = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         part_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         part_ff  <= part_in;
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
      fend_ff <= fend_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_code_word = word_ff;
   assign rsp_frame_end = fend_ff;

endmodule

`default_nettype wire

@@ src/rvl_depth_compressor.sv @@
// rvl_depth_compressor: run length plus variable length depth image compressor
// depends on rvlc_pkg and rvlc_packer
//
//   channel  | ports                                      | moves
//   ---------+--------------------------------------------+------------------------------
//   request  | req_valid req_ready req_pixel req_last_pixel | one depth pixel per transaction
//   response | rsp_valid rsp_ready rsp_code_word rsp_frame_end | one packed 32-bit word
//
// a pixel that closes no group is accepted in S_IDLE, then handled in the S_STEP state
// a group goes out as vle nibbles from the 3-bit digit shifter, with an S_LOAD state
// before each buffered delta for the registered delta memory read
// reset is synchronous and active high; it clears counters, previous pixel and packer
// a stalled response channel stops the nibble shifter; no new pixel is taken until
// all words of the current pixel have entered the packer
`default_nettype none

module rvl_depth_compressor
   import rvlc_pkg::*;
#(
   parameter int MAX_RUN    = 32,
   parameter int PIXEL_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [PIXEL_W-1:0] req_pixel,
   input  wire logic               req_last_pixel,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [WORD_W-1:0]       rsp_code_word,
   output logic                    rsp_frame_end
);

   localparam int CNT_W   = $clog2(MAX_RUN + 1);
   localparam int ADDR_W  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
   localparam int DELTA_W = PIXEL_BITS + 1;

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a pixel
   localparam logic [1:0] S_STEP  = 2'd1;  // pre-flush check, then counter update
   localparam logic [1:0] S_SHIFT = 2'd2;  // one vle nibble per cycle while the packer takes it
   localparam logic [1:0] S_LOAD  = 2'd3;  // delta read data lands in shifter

   // which value of the group is in the shifter
   localparam logic [1:0] K_ZR    = 2'd0;
   localparam logic [1:0] K_NZ    = 2'd1;
   localparam logic [1:0] K_DELTA = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [PIXEL_BITS-1:0] pix_ff, pix_in;
   logic                  last_ff, last_in;
   logic [PIXEL_BITS-1:0] prev_ff, prev_in;
   logic [ZRUN_W-1:0]     zrun_ff, zrun_in;
   logic [CNT_W-1:0]      nz_ff, nz_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [1:0]            kind_ff, kind_in;
   logic                  eof_ff, eof_in;
   logic [ZRUN_W-1:0]     vle_ff, vle_in;

   // delta buffer
   logic [DELTA_W-1:0]    delta_mem [MAX_RUN];
   logic [DELTA_W-1:0]    rd_ff;
   logic                  wr_en;

   logic                  pix_zero;
   logic [DELTA_W-1:0]    diff;
   logic [DELTA_W-1:0]    zigzag;
   logic                  pre_emit;
   logic [ZRUN_W-1:0]     zrun_upd;
   logic [ZRUN_W-1:0]     vle_rest;
   logic                  more;
   logic [CNT_W-1:0]      idx_next;
   logic                  group_done;
   nibble_type            nib;
   logic                  nib_valid;
   logic                  nib_ready;

   assign req_ready = (state_ff == S_IDLE);

   // zigzag code of the pixel delta, sign taken from the extra difference bit
   assign pix_zero = (pix_ff == '0);
   assign diff     = {1'b0, pix_ff} - {1'b0, prev_ff};
   assign zigzag   = {diff[PIXEL_BITS-1:0], 1'b0} ^ {DELTA_W{diff[PIXEL_BITS]}};

   // a zero pixel closes a pending nonzero run or a saturated zero run,
   // a nonzero pixel closes a full buffer
   assign pre_emit = pix_zero ? (nz_ff != '0 || zrun_ff == ZRUN_MAX)
                              : (nz_ff == CNT_W'(MAX_RUN));
   assign zrun_upd = pix_zero ? zrun_ff + 1'b1 : zrun_ff;

   // digit shifter: low three bits out, continuation when anything is left
   assign vle_rest   = vle_ff >> VLE_DIGIT_W;
   assign more       = (vle_rest != '0);
   assign idx_next   = idx_ff + 1'b1;
   assign group_done = !more && ((kind_ff == K_NZ && nz_ff == '0) ||
                                 (kind_ff == K_DELTA && idx_next == nz_ff));

   assign nib_valid     = (state_ff == S_SHIFT);
   assign nib.code      = {more, vle_ff[VLE_DIGIT_W-1:0]};
   assign nib.frame_end = eof_ff && group_done;

   always_comb begin
      state_in = state_ff;
      pix_in   = pix_ff;
      last_in  = last_ff;
      prev_in  = prev_ff;
      zrun_in  = zrun_ff;
      nz_in    = nz_ff;
      idx_in   = idx_ff;
      kind_in  = kind_ff;
      eof_in   = eof_ff;
      vle_in   = vle_ff;
      wr_en    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pix_in   = req_pixel[PIXEL_BITS-1:0];
               last_in  = req_last_pixel;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (pre_emit) begin
               // flush the pending group, come back here for the update
               vle_in   = zrun_ff;
               kind_in  = K_ZR;
               eof_in   = 1'b0;
               state_in = S_SHIFT;
            end else begin
               if (pix_zero) begin
                  zrun_in = zrun_upd;
               end else begin
                  wr_en   = 1'b1;
                  nz_in   = nz_ff + 1'b1;
                  prev_in = pix_ff;
               end
               if (last_ff) begin
                  // closing group of the frame
                  vle_in   = zrun_upd;
                  kind_in  = K_ZR;
                  eof_in   = 1'b1;
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SHIFT: begin
            if (nib_ready) begin
               vle_in = vle_rest;
               if (!more) begin
                  if (group_done) begin
                     zrun_in = '0;
                     nz_in   = '0;
                     if (eof_ff) begin
                        prev_in  = '0;
                        state_in = S_IDLE;
                     end else begin
                        state_in = S_STEP;
                     end
                  end else begin
                     unique case (kind_ff)
                        K_ZR: begin
                           vle_in  = ZRUN_W'(nz_ff);
                           kind_in = K_NZ;
                        end
                        K_NZ: begin
                           idx_in   = '0;
                           kind_in  = K_DELTA;
                           state_in = S_LOAD;
                        end
                        K_DELTA: begin
                           idx_in   = idx_next;
                           state_in = S_LOAD;
                        end
                        default: begin
                           state_in = S_IDLE;
                        end
                     endcase
                  end
               end
            end
         end
         S_LOAD: begin
            vle_in   = ZRUN_W'(rd_ff);
            state_in = S_SHIFT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // delta memory: write at the run position, read registered from the next index for the load
   always_ff @(posedge clock) begin
      if (wr_en) begin
         delta_mem[nz_ff[ADDR_W-1:0]] <= zigzag;
      end
      rd_ff <= delta_mem[idx_in[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         prev_ff  <= '0;
         zrun_ff  <= '0;
         nz_ff    <= '0;
      end else begin
         state_ff <= state_in;
         prev_ff  <= prev_in;
         zrun_ff  <= zrun_in;
         nz_ff    <= nz_in;
      end
      pix_ff  <= pix_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
      kind_ff <= kind_in;
      eof_ff  <= eof_in;
      vle_ff  <= vle_in;
   end

   // word packing and response register
   rvlc_packer u_packer (
      .clock         (clock),
      .reset         (reset),
      .nib_valid     (nib_valid),
      .nib           (nib),
      .nib_ready     (nib_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_word (rsp_code_word),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

@@ bench/rvlc_stream_checker.sv @@
// rvlc_stream_checker: watches the pixel and code word channels of the depth compressor
// predicts the packed vle words per pixel and compares them; depends on rvlc_pkg
`timescale 1ns / 1ps

module rvlc_stream_checker
   import rvlc_pkg::*;
#(
   parameter int MAX_RUN    = 32,
   parameter int PIXEL_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [PIXEL_W-1:0] req_pixel,
   input  wire logic               req_last_pixel,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [WORD_W-1:0]  rsp_code_word,
   input  wire logic               rsp_frame_end,
   output int                      mismatch_count,
   output int                      pending_words
);

   localparam int DELTA_W = 17;
   localparam int BUF_DEPTH = 32;
   localparam logic [PIXEL_W-1:0] DEPTH_MASK = {PIXEL_W{1'b1}} >> (PIXEL_W - PIXEL_BITS);

   typedef struct packed {
      logic [WORD_W-1:0] code_word;
      logic              frame_end;
   } coded_word_type;

   coded_word_type     expected_words[$];
   coded_word_type     step_words[$];

   logic [PIXEL_W-1:0] prev_depth;
   logic [ZRUN_W-1:0]  zero_count;
   int                 nz_count;
   logic [DELTA_W-1:0] delta_buf [BUF_DEPTH];
   logic [WORD_W-1:0]  word_acc;
   int                 nib_fill;

   initial begin
      mismatch_count = 0;
      pending_words  = 0;
   end

   task automatic push_nibble(input logic [NIBBLE_W-1:0] nib);
      word_acc = {word_acc[WORD_W-NIBBLE_W-1:0], nib};
      nib_fill++;
      if (nib_fill == NIBBLES_PER_WORD) begin
         step_words.push_back({word_acc, 1'b0});
         word_acc = '0;
         nib_fill = 0;
      end
   endtask

   // 3 data bits per nibble, low digits first, top bit flags a following nibble
   task automatic push_code(input logic [ZRUN_W-1:0] value);
      logic [ZRUN_W-1:0]   rest;
      logic [NIBBLE_W-1:0] nib;
      rest = value;
      do begin
         nib  = {1'b0, rest[VLE_DIGIT_W-1:0]};
         rest = rest >> VLE_DIGIT_W;
         if (rest != '0) nib[NIBBLE_W-1] = 1'b1;
         push_nibble(nib);
      end while (rest != '0);
   endtask

   task automatic flush_group();
      push_code(zero_count);
      push_code(ZRUN_W'(nz_count));
      for (int i = 0; i < nz_count; i++) push_code(ZRUN_W'(delta_buf[i]));
      zero_count = '0;
      nz_count   = 0;
   endtask

   task automatic encode_pixel(input logic [PIXEL_W-1:0] pixel, input logic last);
      logic [PIXEL_W-1:0] depth;
      logic [31:0]        diff;
      logic [31:0]        zigzag;
      coded_word_type     tail;
      depth = pixel & DEPTH_MASK;
      step_words.delete();
      if (depth == '0) begin
         if (nz_count > 0) flush_group();
         if (zero_count == ZRUN_MAX) flush_group();
         zero_count++;
      end else begin
         if (nz_count >= MAX_RUN) flush_group();
         diff   = {16'b0, depth} - {16'b0, prev_depth};
         zigzag = (diff << 1) ^ {32{diff[31]}};
         delta_buf[nz_count % BUF_DEPTH] = zigzag[DELTA_W-1:0];
         nz_count++;
         prev_depth = depth;
      end
      if (last) begin
         flush_group();
         if (nib_fill != 0) begin
            step_words.push_back({word_acc << (NIBBLE_W * (NIBBLES_PER_WORD - nib_fill)), 1'b0});
            word_acc = '0;
            nib_fill = 0;
         end
         tail = step_words.pop_back();
         tail.frame_end = 1'b1;
         step_words.push_back(tail);
         prev_depth = '0;
         zero_count = '0;
         nz_count   = 0;
      end
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endtask

   always @(posedge clock) begin
      coded_word_type want;
      if (reset) begin
         expected_words.delete();
         prev_depth = '0;
         zero_count = '0;
         nz_count   = 0;
         word_acc   = '0;
         nib_fill   = 0;
      end else begin
         // pixel first, so words that leave on this same edge still find their slot
         if (req_valid && req_ready) encode_pixel(req_pixel, req_last_pixel);
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: code_word %h frame_end %b", rsp_code_word, rsp_frame_end);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_code_word !== want.code_word) begin
                  $error("code_word: expected %h, actual %h", want.code_word, rsp_code_word);
                  mismatch_count++;
               end
               if (rsp_frame_end !== want.frame_end) begin
                  $error("frame_end: expected %b, actual %b", want.frame_end, rsp_frame_end);
                  mismatch_count++;
               end
            end
         end
      end
      pending_words = expected_words.size();
   end

endmodule

@@ bench/rvl_depth_compressor_tb.sv @@
// rvl_depth_compressor_tb: pixel stimulus, code word back pressure and verdict
// depends on rvlc_pkg, rvl_depth_compressor and rvlc_stream_checker
`timescale 1ns / 1ps

module rvl_depth_compressor_tb;
   import rvlc_pkg::*;

   localparam int MAX_RUN       = 32;
   localparam int PIXEL_BITS    = 16;
   localparam int ITEM_TARGET   = 460;      // pixel transactions to reach in all, directed frames included
   localparam int SETTLE_CYCLES = 200;      // idle time after the drain, so a stray extra word is still caught
   localparam int CYCLE_LIMIT   = 1_500_000;

   // how the pixels of one nonzero run are chosen
   typedef enum int {RUN_SMOOTH, RUN_RANDOM, RUN_EXTREME} run_style_type;
   // receiver back pressure modes
   typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_PERIODIC} stall_mode_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   logic [PIXEL_W-1:0] req_pixel      = '0;
   logic               req_last_pixel = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic [WORD_W-1:0]  rsp_code_word;
   logic               rsp_frame_end;

   int                 mismatch_count;
   int                 pending_words;
   int                 pixels_sent = 0;
   int                 burst_left  = 0;
   int                 cycle_count = 0;

   stall_mode_type     stall_mode  = STALL_NONE;
   int                 stall_left  = 0;
   int                 stall_phase = 0;

   rvl_depth_compressor #(
      .MAX_RUN    (MAX_RUN),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_word  (rsp_code_word),
      .rsp_frame_end  (rsp_frame_end)
   );

   rvlc_stream_checker #(
      .MAX_RUN    (MAX_RUN),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_word  (rsp_code_word),
      .rsp_frame_end  (rsp_frame_end),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rvl_depth_compressor_tb failed");
         $finish;
      end
   end

   // receiver back pressure: each mode holds for a random stretch of cycles,
   // so stalls land on every phase of the nibble shifter and packer
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
         STALL_NONE:     rsp_ready <= 1'b1;
         STALL_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
         STALL_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
         default:        rsp_ready <= ((stall_phase % 8) >= 5);
      endcase
   end

   // one pixel transaction; the sender runs in bursts with random gaps,
   // and valid stays high across back-to-back transactions of one burst
   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_pixel      <= pixel;
      req_last_pixel <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pixels_sent++;
   endtask

   // hold the sender off until every predicted word has come out
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
   endtask

   // one random frame: nonzero runs, each sometimes led by a zero run, sometimes one long run straddling
   // the delta buffer depth, sometimes trailing zeros, sometimes pure noise
   task automatic send_random_frame(input bit force_long);
      logic [PIXEL_W-1:0] frame_px[$];
      int                 segments;
      int                 len;
      int                 level;
      bit                 long_frame;
      run_style_type      style;
      segments   = $urandom_range(1, 5);
      long_frame = force_long || ($urandom_range(0, 5) == 0);
      level      = $urandom_range(1, 65535);
      if (!force_long && $urandom_range(0, 7) == 0) begin
         // noise frame: zero and arbitrary pixels mixed at random
         repeat ($urandom_range(1, 30))
            frame_px.push_back($urandom_range(0, 1) ? PIXEL_W'($urandom_range(0, 65535)) : '0);
      end else begin
         for (int s = 0; s < segments; s++) begin
            if ($urandom_range(0, 2) != 0) begin
               len = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 6);
               repeat (len) frame_px.push_back('0);
            end
            // long runs straddle the buffer depth, one and two buffers' worth
            if (long_frame && s == 0) len = $urandom_range(MAX_RUN - 1, 2 * MAX_RUN + 6);
            else len = $urandom_range(1, 12);
            style = run_style_type'($urandom_range(0, 2));
            repeat (len) begin
               case (style)
                  RUN_SMOOTH: begin
                     level = level + $urandom_range(0, 32) - 16;
                     if (level < 1) level = 1;
                     if (level > 65535) level = 65535;
                  end
                  RUN_RANDOM: level = $urandom_range(1, 65535);
                  default:    level = $urandom_range(0, 1) ? 65535 : 1;
               endcase
               frame_px.push_back(level[PIXEL_W-1:0]);
            end
         end
         // frame closing on a zero pixel
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) frame_px.push_back('0);
      end
      foreach (frame_px[i]) send_pixel(frame_px[i], i == frame_px.size() - 1);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: single-pixel frames, zero and full scale
      send_pixel(16'h0000, 1'b1);
      send_pixel(16'hFFFF, 1'b1);
      // zero run, full-swing deltas both ways, frame closing on a nonzero pixel
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h0001, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0001, 1'b0);
      send_pixel(16'hAAAA, 1'b0);
      send_pixel(16'h5555, 1'b0);
      send_pixel(16'h8000, 1'b0);
      send_pixel(16'h7FFF, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b1);
      // small deltas, then a frame closing on zero pixels
      send_pixel(16'h1234, 1'b0);
      send_pixel(16'h1235, 1'b0);
      send_pixel(16'h1233, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h0000, 1'b1);
      wait_drained();

      // first random frame always has a long run straddling the delta buffer depth
      send_random_frame(1'b1);
      while (pixels_sent < ITEM_TARGET) begin
         send_random_frame(1'b0);
         if ($urandom_range(0, 9) == 0) wait_drained();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_words == 0) begin
         $display("rvl_depth_compressor_tb passed");
      end else begin
         $display("rvl_depth_compressor_tb failed");
      end
      $finish;
   end

endmodule

@@ rvl_depth_compressor.f @@
src/rvlc_pkg.sv
src/rvlc_packer.sv
src/rvl_depth_compressor.sv
bench/rvlc_stream_checker.sv
bench/rvl_depth_compressor_tb.sv
